@@ design/frd_pkg.sv @@
// ----------------------------------------------------------------------------
// frd_pkg: shared types and constants of the RPC frame deframer
// Phase codes, result kinds, report status codes, register indexes and the
// structs passed between the deframer's modules.
// ----------------------------------------------------------------------------
package frd_pkg;

  localparam int unsigned DEF_MAX_ID_LEN   = 100;
  localparam int unsigned DEF_MAX_TEXT_LEN = 512;

  // start byte and end byte (2) plus the six fixed words, frame length word included (24)
  localparam int unsigned FRAME_OVERHEAD = 2 + 24;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FLEN_W     = 24;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 2'd2;

  localparam logic [BYTE_W-1:0] RST_START_BYTE    = 8'd2;
  localparam logic [BYTE_W-1:0] RST_END_BYTE      = 8'd3;
  localparam logic [FLEN_W-1:0] RST_MAX_FRAME_LEN = 24'd65536;

  localparam logic [KIND_W-1:0] KIND_ID     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_METHOD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ECODE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TEXT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PAYLD  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REPORT = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_END  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_LEN_BAD  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_TOO_LONG = 2'd3;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_FLEN    = 4'd1,
    PH_IDLEN   = 4'd2,
    PH_ID      = 4'd3,
    PH_MLEN    = 4'd4,
    PH_METHOD  = 4'd5,
    PH_ECODE   = 4'd6,
    PH_TLEN    = 4'd7,
    PH_TEXT    = 4'd8,
    PH_PAYLOAD = 4'd9,
    PH_CSUM    = 4'd10,
    PH_END     = 4'd11,
    PH_SKIP    = 4'd12
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [FLEN_W-1:0] max_frame_len;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] value;
    logic              last_in_field;
    logic [STAT_W-1:0] status;
  } result_t;

endpackage

@@ design/frd_ifs.sv @@
// ----------------------------------------------------------------------------
// frd_ifs: channel interfaces of the RPC frame deframer
// Byte input channel, result channel and register write channel, each with
// valid/ready handshake and source/sink modports.
// ----------------------------------------------------------------------------
interface frd_in_if;
  logic                        valid;
  logic                        ready;
  logic [frd_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frd_out_if;
  logic                        valid;
  logic                        ready;
  logic [frd_pkg::KIND_W-1:0]  kind;
  logic [frd_pkg::WORD_W-1:0]  value;
  logic                        last_in_field;
  logic [frd_pkg::STAT_W-1:0]  status;

  modport source (output valid, output kind, output value, output last_in_field,
                  output status, input ready);
  modport sink   (input valid, input kind, input value, input last_in_field,
                  input status, output ready);
endinterface

interface frd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [frd_pkg::CFG_IDX_W-1:0]   index;
  logic [frd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/frd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// frd_cfg_regs: configuration registers
// Start byte, end byte and longest accepted frame length, written through
// the register write channel.
// ----------------------------------------------------------------------------
module frd_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  frd_cfg_if.sink           cfg_ch,
  output frd_pkg::cfg_t     cfg
);

  frd_pkg::cfg_t cfg_r;
  frd_pkg::cfg_t cfg_nxt;
  logic          wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_ch.index)
        frd_pkg::CFG_START_BYTE:    cfg_nxt.start_byte    = cfg_ch.data[frd_pkg::BYTE_W-1:0];
        frd_pkg::CFG_END_BYTE:      cfg_nxt.end_byte      = cfg_ch.data[frd_pkg::BYTE_W-1:0];
        frd_pkg::CFG_MAX_FRAME_LEN: cfg_nxt.max_frame_len = cfg_ch.data;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte    <= frd_pkg::RST_START_BYTE;
      cfg_r.end_byte      <= frd_pkg::RST_END_BYTE;
      cfg_r.max_frame_len <= frd_pkg::RST_MAX_FRAME_LEN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/frd_parser.sv @@
// ----------------------------------------------------------------------------
// frd_parser: frame parsing state machine
// Consumes one byte per enabled cycle, tracks the frame phase, lengths and
// counts, and produces at most one tagged result for that byte.
// ----------------------------------------------------------------------------
module frd_parser #(
  parameter int unsigned MAX_ID_LEN   = frd_pkg::DEF_MAX_ID_LEN,
  parameter int unsigned MAX_TEXT_LEN = frd_pkg::DEF_MAX_TEXT_LEN
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [frd_pkg::BYTE_W-1:0]  rx_byte,
  input  frd_pkg::cfg_t               cfg,
  output logic                        has_res,
  output frd_pkg::result_t            res
);

  // widest possible sum of the three field lengths
  localparam int unsigned SUM_W = $clog2(MAX_ID_LEN + 2 * MAX_TEXT_LEN + 1);
  localparam int unsigned TOT_W = frd_pkg::FLEN_W + 1;
  localparam int unsigned FL_W  = frd_pkg::FLEN_W;

  frd_pkg::phase_t phase_r, phase_nxt;
  logic [FL_W-1:0]  frame_length_r, frame_length_nxt;
  logic [FL_W-1:0]  bytes_seen_r, bytes_seen_nxt;
  logic [FL_W-1:0]  field_rem_r, field_rem_nxt;
  logic [FL_W-1:0]  payload_r, payload_nxt;
  logic [23:0]      word_shift_r, word_shift_nxt;
  logic [1:0]       word_count_r, word_count_nxt;
  logic [SUM_W-1:0] length_sum_r, length_sum_nxt;
  logic [frd_pkg::STAT_W-1:0] frame_error_r, frame_error_nxt;

  logic [frd_pkg::WORD_W-1:0] w;
  logic                       word_ph;
  logic                       word_done;
  logic [FL_W-1:0]            seen_inc;
  logic                       len_over;
  logic [SUM_W-1:0]           len_nar;
  logic [TOT_W-1:0]           total;
  logic                       overrun;
  logic [FL_W-1:0]            pay_len;
  logic                       field_last;
  logic                       flen_long;
  logic                       flen_short;
  logic                       start_hit;

  assign w          = {word_shift_r, rx_byte};
  assign word_done  = (word_count_r == 2'd3);
  assign seen_inc   = bytes_seen_r + 1'b1;
  assign field_last = (field_rem_r == FL_W'(1));
  assign start_hit  = (rx_byte == cfg.start_byte);
  assign flen_long  = (w > {8'd0, cfg.max_frame_len});
  assign flen_short = (w < frd_pkg::WORD_W'(frd_pkg::FRAME_OVERHEAD));

  always_comb begin
    word_ph = phase_r inside {frd_pkg::PH_FLEN, frd_pkg::PH_IDLEN, frd_pkg::PH_MLEN,
                              frd_pkg::PH_ECODE, frd_pkg::PH_TLEN, frd_pkg::PH_CSUM};
  end

  // length word checks: against the field limit, then against the frame length
  assign len_over = (phase_r == frd_pkg::PH_IDLEN) ? (w > frd_pkg::WORD_W'(MAX_ID_LEN))
                                                  : (w > frd_pkg::WORD_W'(MAX_TEXT_LEN));
  assign len_nar  = w[SUM_W-1:0];
  assign total    = TOT_W'(frd_pkg::FRAME_OVERHEAD) + TOT_W'(length_sum_r) + TOT_W'(len_nar);
  assign overrun  = (total > {1'b0, frame_length_r});
  assign pay_len  = frame_length_r - total[FL_W-1:0];

  // next state
  always_comb begin
    phase_nxt        = phase_r;
    frame_length_nxt = frame_length_r;
    bytes_seen_nxt   = bytes_seen_r;
    field_rem_nxt    = field_rem_r;
    payload_nxt      = payload_r;
    word_shift_nxt   = word_shift_r;
    word_count_nxt   = word_count_r;
    length_sum_nxt   = length_sum_r;
    frame_error_nxt  = frame_error_r;

    if (fire) begin
      if (phase_r == frd_pkg::PH_HUNT) begin
        if (start_hit) begin
          phase_nxt        = frd_pkg::PH_FLEN;
          word_count_nxt   = 2'd0;
          frame_length_nxt = '0;
          bytes_seen_nxt   = FL_W'(1);
          length_sum_nxt   = '0;
          frame_error_nxt  = frd_pkg::STAT_OK;
          field_rem_nxt    = '0;
        end
      end else begin
        bytes_seen_nxt = seen_inc;
        if (word_ph) begin
          word_shift_nxt = w[23:0];
          word_count_nxt = word_count_r + 2'd1;
        end
        case (phase_r)
          frd_pkg::PH_FLEN: begin
            if (word_done) begin
              frame_length_nxt = w[FL_W-1:0];
              if (flen_long || flen_short) begin
                phase_nxt = frd_pkg::PH_HUNT;
              end else begin
                phase_nxt = frd_pkg::PH_IDLEN;
              end
            end
          end
          frd_pkg::PH_IDLEN, frd_pkg::PH_MLEN, frd_pkg::PH_TLEN: begin
            if (word_done) begin
              if (len_over) begin
                frame_error_nxt = frd_pkg::STAT_TOO_LONG;
                phase_nxt       = frd_pkg::PH_SKIP;
              end else if (overrun) begin
                frame_error_nxt = frd_pkg::STAT_LEN_BAD;
                phase_nxt       = frd_pkg::PH_SKIP;
              end else begin
                length_sum_nxt = length_sum_r + len_nar;
                field_rem_nxt  = FL_W'(len_nar);
                payload_nxt    = pay_len;
                case (phase_r)
                  frd_pkg::PH_IDLEN:
                    phase_nxt = (len_nar != '0) ? frd_pkg::PH_ID : frd_pkg::PH_MLEN;
                  frd_pkg::PH_MLEN:
                    phase_nxt = (len_nar != '0) ? frd_pkg::PH_METHOD : frd_pkg::PH_ECODE;
                  default: begin
                    if (len_nar != '0) begin
                      phase_nxt = frd_pkg::PH_TEXT;
                    end else begin
                      // empty text: go straight to the payload, or to the checksum if the payload is empty
                      field_rem_nxt = pay_len;
                      phase_nxt = (pay_len != '0) ? frd_pkg::PH_PAYLOAD : frd_pkg::PH_CSUM;
                    end
                  end
                endcase
              end
            end
          end
          frd_pkg::PH_ID: begin
            field_rem_nxt = field_rem_r - 1'b1;
            if (field_last) phase_nxt = frd_pkg::PH_MLEN;
          end
          frd_pkg::PH_METHOD: begin
            field_rem_nxt = field_rem_r - 1'b1;
            if (field_last) phase_nxt = frd_pkg::PH_ECODE;
          end
          frd_pkg::PH_ECODE: begin
            if (word_done) phase_nxt = frd_pkg::PH_TLEN;
          end
          frd_pkg::PH_TEXT: begin
            field_rem_nxt = field_rem_r - 1'b1;
            if (field_last) begin
              field_rem_nxt = payload_r;
              phase_nxt = (payload_r != '0) ? frd_pkg::PH_PAYLOAD : frd_pkg::PH_CSUM;
            end
          end
          frd_pkg::PH_PAYLOAD: begin
            field_rem_nxt = field_rem_r - 1'b1;
            if (field_last) phase_nxt = frd_pkg::PH_CSUM;
          end
          frd_pkg::PH_CSUM: begin
            if (word_done) phase_nxt = frd_pkg::PH_END;
          end
          frd_pkg::PH_END: begin
            phase_nxt = frd_pkg::PH_HUNT;
          end
          frd_pkg::PH_SKIP: begin
            if (seen_inc >= frame_length_r) phase_nxt = frd_pkg::PH_HUNT;
          end
          default: begin
            phase_nxt = frd_pkg::PH_HUNT;
          end
        endcase
      end
    end
  end

  // result for the current byte
  always_comb begin
    has_res           = 1'b0;
    res.kind          = frd_pkg::KIND_REPORT;
    res.value         = {24'd0, rx_byte};
    res.last_in_field = 1'b0;
    res.status        = frd_pkg::STAT_OK;
    case (phase_r)
      frd_pkg::PH_FLEN: begin
        if (word_done && (flen_long || flen_short)) begin
          has_res    = 1'b1;
          res.value  = w;
          res.status = flen_long ? frd_pkg::STAT_TOO_LONG : frd_pkg::STAT_LEN_BAD;
        end
      end
      frd_pkg::PH_ID, frd_pkg::PH_METHOD, frd_pkg::PH_TEXT, frd_pkg::PH_PAYLOAD: begin
        has_res           = 1'b1;
        res.last_in_field = field_last;
        case (phase_r)
          frd_pkg::PH_ID:     res.kind = frd_pkg::KIND_ID;
          frd_pkg::PH_METHOD: res.kind = frd_pkg::KIND_METHOD;
          frd_pkg::PH_TEXT:   res.kind = frd_pkg::KIND_TEXT;
          default:            res.kind = frd_pkg::KIND_PAYLD;
        endcase
      end
      frd_pkg::PH_ECODE: begin
        if (word_done) begin
          has_res           = 1'b1;
          res.kind          = frd_pkg::KIND_ECODE;
          res.value         = w;
          res.last_in_field = 1'b1;
        end
      end
      frd_pkg::PH_END: begin
        has_res    = 1'b1;
        res.value  = {8'd0, frame_length_r};
        res.status = (rx_byte == cfg.end_byte) ? frd_pkg::STAT_OK : frd_pkg::STAT_BAD_END;
      end
      frd_pkg::PH_SKIP: begin
        if (seen_inc >= frame_length_r) begin
          has_res    = 1'b1;
          res.value  = {8'd0, frame_length_r};
          res.status = frame_error_r;
        end
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= frd_pkg::PH_HUNT;
      frame_length_r <= '0;
      bytes_seen_r   <= '0;
      field_rem_r    <= '0;
      payload_r      <= '0;
      word_shift_r   <= '0;
      word_count_r   <= '0;
      length_sum_r   <= '0;
      frame_error_r  <= frd_pkg::STAT_OK;
    end else begin
      phase_r        <= phase_nxt;
      frame_length_r <= frame_length_nxt;
      bytes_seen_r   <= bytes_seen_nxt;
      field_rem_r    <= field_rem_nxt;
      payload_r      <= payload_nxt;
      word_shift_r   <= word_shift_nxt;
      word_count_r   <= word_count_nxt;
      length_sum_r   <= length_sum_nxt;
      frame_error_r  <= frame_error_nxt;
    end
  end

  // a frame report always sends the parser back to hunting
  a_report_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && has_res && res.kind == frd_pkg::KIND_REPORT) |=> (phase_r == frd_pkg::PH_HUNT))
    else $error("report without return to hunting");

  // data results carry no status
  a_data_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (has_res && res.kind != frd_pkg::KIND_REPORT) |-> (res.status == frd_pkg::STAT_OK))
    else $error("status set on a data result");

  // partial words only exist inside word phases
  a_word_count_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (word_count_r != 2'd0) |-> (phase_r == frd_pkg::PH_FLEN || phase_r == frd_pkg::PH_IDLEN ||
      phase_r == frd_pkg::PH_MLEN || phase_r == frd_pkg::PH_ECODE ||
      phase_r == frd_pkg::PH_TLEN || phase_r == frd_pkg::PH_CSUM))
    else $error("word count left over outside a word phase");

  // a skipped frame is entered before its declared end
  a_skip_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == frd_pkg::PH_SKIP) |-> (bytes_seen_r < frame_length_r))
    else $error("skip phase past end of frame");

endmodule

@@ design/frd_out_stage.sv @@
// ----------------------------------------------------------------------------
// frd_out_stage: result register
// Holds one result item until the sink takes it; loads a new one whenever
// the register is empty or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module frd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              has_res,
  input  frd_pkg::result_t  res,
  output logic              can_load,
  frd_out_if.source         out_ch
);

  logic             valid_r, valid_nxt;
  frd_pkg::result_t data_r, data_nxt;

  assign can_load = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = has_res;
      data_nxt  = res;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.kind          = data_r.kind;
  assign out_ch.value         = data_r.value;
  assign out_ch.last_in_field = data_r.last_in_field;
  assign out_ch.status        = data_r.status;

endmodule

@@ design/rpc_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// rpc_frame_deframer: byte-serial deframer for length-prefixed RPC frames
// Hunts for the start byte, parses the frame fields and emits tagged field
// items followed by one report item per frame.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock and gives at most one result
// per byte: a sustained rate of one byte per cycle whenever the result side
// keeps up. A byte passes an input register, one pass of the parsing state
// machine and the result register before its result is on the result channel.
// A result waiting in the result register does not stop the next byte from
// entering; only a full result register that is not being taken holds the
// pipeline. Configuration writes are taken in any cycle and are meant to
// happen while no frame is in flight.
module rpc_frame_deframer #(
  parameter int unsigned MAX_ID_LEN   = frd_pkg::DEF_MAX_ID_LEN,
  parameter int unsigned MAX_TEXT_LEN = frd_pkg::DEF_MAX_TEXT_LEN
) (
  input  logic        clk,
  input  logic        rst_n,
  frd_in_if.sink      in_ch,
  frd_out_if.source   out_ch,
  frd_cfg_if.sink     cfg_ch
);

  logic                        in_valid_r, in_valid_nxt;
  logic [frd_pkg::BYTE_W-1:0]  in_byte_r, in_byte_nxt;
  logic                        advance;
  logic                        can_load;
  logic                        has_res;
  frd_pkg::result_t            res;
  frd_pkg::cfg_t               cfg;

  // advance the held byte into the parser when the result register can load
  assign advance     = in_valid_r && can_load;
  assign in_ch.ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_byte_nxt  = in_byte_r;
    if (in_ch.ready) begin
      in_valid_nxt = in_ch.valid;
      in_byte_nxt  = in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_byte_r <= in_byte_nxt;
  end

  frd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  frd_parser #(
    .MAX_ID_LEN   (MAX_ID_LEN),
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .has_res (has_res),
    .res     (res)
  );

  frd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance),
    .has_res  (has_res),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule
